>>> design/lphtb_pkg.sv
// Package: table size, codes, entry type and key helpers for the hash table.
`default_nettype none
package lphtb_pkg;
	localparam int SLOTS      = 256;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int CNT_W      = SLOT_W + 1;
	localparam int FULL_LIMIT = SLOTS / 2;
	localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
	localparam int FNV_SHIFT  = 40;
	localparam logic [63:0] FNV_LO = 64'd435;

	typedef enum logic [2:0] {
		MODE_INSERT = 3'd0,
		MODE_FIND   = 3'd1,
		MODE_UPDATE = 3'd2,
		MODE_SET    = 3'd3,
		MODE_ERASE  = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_MISSING  = 3'd1,
		STAT_EXISTS   = 3'd2,
		STAT_MISMATCH = 3'd3,
		STAT_FULL     = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_HASH,
		S_PROBE,
		S_CMP,
		S_ESCAN,
		S_EWALK,
		S_EHSTART,
		S_EHASH,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [63:0] key;
		logic [31:0] value;
		logic [2:0]  dtype;
	} entry_t;

	function automatic logic [63:0] key_trim(input logic [63:0] k);
		logic [63:0] r;
		logic        z;
		r = '0;
		z = 1'b0;
		for (int b = 0; b < 8; b++) begin
			if (k[8*b +: 8] == 8'd0) z = 1'b1;
			if (!z) r[8*b +: 8] = k[8*b +: 8];
		end
		return r;
	endfunction

	function automatic logic [63:0] fnv_mul(input logic [63:0] x);
		return (x << FNV_SHIFT) + (x * FNV_LO);
	endfunction
endpackage
`default_nettype wire

>>> design/lphtb_if.sv
// Interfaces: request and response channels of the hash table.
`default_nettype none
interface lphtb_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic [63:0] key;
	logic [31:0] data_value;
	logic [2:0]  data_type;
	modport source(output valid, mode, key, data_value, data_type, input ready);
	modport sink(input valid, mode, key, data_value, data_type, output ready);
endinterface

interface lphtb_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [8:0]  slot;
	logic [31:0] found_value;
	logic [2:0]  found_type;
	logic [8:0]  entry_count;
	modport source(output valid, status, slot, found_value, found_type, entry_count,
		input ready);
	modport sink(input valid, status, slot, found_value, found_type, entry_count,
		output ready);
endinterface
`default_nettype wire

>>> design/lphtb_hash.sv
// Iterative FNV-1a hash: one key byte per cycle, then a done strobe with the home slot.
`default_nettype none
module lphtb_hash (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [63:0]                key,
	output logic                            done,
	output logic [lphtb_pkg::SLOT_W-1:0]    home
);
	import lphtb_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic        stop_q;
	logic [2:0]  cnt_q;
	logic [63:0] h_q;
	logic [63:0] k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			h_q    <= FNV_BASIS;
			k_q    <= key;
			stop_q <= 1'b0;
		end else if (busy_q) begin
			k_q <= k_q >> 8;
			if (!stop_q && k_q[7:0] != 8'd0) begin
				h_q <= fnv_mul(h_q ^ {56'd0, k_q[7:0]});
			end else begin
				stop_q <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign home = h_q[SLOT_W-1:0];
endmodule
`default_nettype wire

>>> design/linear_probing_hash_table_unit.sv
// Top level: sequencer, entry memory and occupancy bits of the hash table.
//
//  channel  dir  word
//  req      in   mode, key, data_value, data_type
//  rsp      out  status, slot, found_value, found_type, entry_count
//
// An item is hashed, then each occupied slot probed is read and its key compared, and
// an empty slot ends the probe before the result is posted; the hash unit and the
// entry memory reads set the pace.
// Erase scans the cluster tail, then walks back from its end, re-hashing each entry's
// home and shifting it into the hole when the hole lies between home and entry.
// Reset clears occupancy bits and the count at once; entry data is not cleared.
// A finished word waits in the output register while the next item is taken.
`default_nettype none
module linear_probing_hash_table_unit (
	input  wire logic   clk,
	input  wire logic   arst_n,
	lphtb_req_if.sink   req,
	lphtb_rsp_if.source rsp
);
	import lphtb_pkg::*;

	state_t              state_q, state_d;
	logic [SLOTS-1:0]    used_q, used_d;
	entry_t              mem [SLOTS];
	entry_t              rd_q;
	logic                mem_we, mem_re;
	logic [SLOT_W-1:0]   mem_waddr, mem_raddr;
	entry_t              mem_wdata;

	logic [2:0]          mode_q;
	logic [63:0]         key_q;
	logic [31:0]         val_q;
	logic [2:0]          typ_q;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [SLOT_W-1:0]   idx_q, idx_d;
	logic [SLOT_W-1:0]   n_q, n_d;
	logic [SLOT_W-1:0]   hole_q, hole_d;
	logic [SLOT_W-1:0]   e_q, e_d;
	logic [SLOT_W-1:0]   end_q, end_d;
	logic [2:0]          st_q, st_d;
	logic [CNT_W-1:0]    sl_q, sl_d;
	logic [31:0]         fv_q, fv_d;
	logic [2:0]          ft_q, ft_d;
	logic                set_used, clr_used;
	logic [SLOT_W-1:0]   set_idx, clr_idx;

	logic                out_valid_q;
	logic [2:0]          out_st_q;
	logic [CNT_W-1:0]    out_sl_q;
	logic [31:0]         out_fv_q;
	logic [2:0]          out_ft_q;
	logic [CNT_W-1:0]    out_cnt_q;

	logic                accept;
	logic                hash_start, hash_done;
	logic [63:0]         hkey;
	logic [SLOT_W-1:0]   hash_home;
	logic                full;
	logic                load_out;

	lphtb_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (hkey),
		.done   (hash_done),
		.home   (hash_home)
	);

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign full      = (count_q > CNT_W'(FULL_LIMIT));
	assign load_out  = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		idx_d      = idx_q;
		n_d        = n_q;
		hole_d     = hole_q;
		e_d        = e_q;
		end_d      = end_q;
		st_d       = st_q;
		sl_d       = sl_q;
		fv_d       = fv_q;
		ft_d       = ft_q;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		mem_waddr  = idx_q;
		mem_raddr  = idx_q;
		mem_wdata  = '{key: key_q, value: val_q, dtype: typ_q};
		set_used   = 1'b0;
		clr_used   = 1'b0;
		set_idx    = idx_q;
		clr_idx    = idx_q;
		hash_start = 1'b0;
		hkey       = key_trim(req.key);
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					st_d = STAT_OK;
					sl_d = CNT_W'(SLOTS);
					fv_d = '0;
					ft_d = '0;
					if (req.mode > MODE_ERASE) begin
						state_d = S_DONE;
					end else if (req.mode == MODE_INSERT && full) begin
						st_d    = STAT_FULL;
						state_d = S_DONE;
					end else begin
						hash_start = 1'b1;
						state_d    = S_HASH;
					end
				end
			end
			S_HASH: begin
				if (hash_done) begin
					idx_d   = hash_home;
					n_d     = '0;
					state_d = S_PROBE;
				end
			end
			S_PROBE: begin
				if (!used_q[idx_q]) begin
					state_d = S_DONE;
					if (mode_q == MODE_INSERT || mode_q == MODE_SET) begin
						if (full) begin
							st_d = STAT_FULL;
						end else begin
							mem_we   = 1'b1;
							set_used = 1'b1;
							count_d  = count_q + CNT_W'(1);
							sl_d     = CNT_W'(idx_q);
						end
					end else begin
						st_d = STAT_MISSING;
					end
				end else begin
					mem_re  = 1'b1;
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				if (rd_q.key == key_q) begin
					sl_d    = CNT_W'(idx_q);
					state_d = S_DONE;
					case (mode_q)
						MODE_INSERT: st_d = STAT_EXISTS;
						MODE_FIND: begin
							ft_d = rd_q.dtype;
							if (rd_q.dtype != typ_q) st_d = STAT_MISMATCH;
							else fv_d = rd_q.value;
						end
						MODE_UPDATE, MODE_SET: mem_we = 1'b1;
						default: begin
							clr_used = 1'b1;
							count_d  = count_q - CNT_W'(1);
							hole_d   = idx_q;
							end_d    = idx_q;
							e_d      = idx_q + SLOT_W'(1);
							state_d  = S_ESCAN;
						end
					endcase
				end else if (n_q == SLOT_W'(SLOTS - 1)) begin
					state_d = S_DONE;
					if (mode_q == MODE_INSERT || mode_q == MODE_SET) st_d = STAT_FULL;
					else st_d = STAT_MISSING;
				end else begin
					idx_d   = idx_q + SLOT_W'(1);
					n_d     = n_q + SLOT_W'(1);
					state_d = S_PROBE;
				end
			end
			S_ESCAN: begin
				if (used_q[e_q]) begin
					end_d = e_q;
					e_d   = e_q + SLOT_W'(1);
				end else begin
					e_d     = end_q;
					state_d = S_EWALK;
				end
			end
			S_EWALK: begin
				if (e_q == hole_q) begin
					state_d = S_DONE;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = e_q;
					state_d   = S_EHSTART;
				end
			end
			S_EHSTART: begin
				hash_start = 1'b1;
				hkey       = rd_q.key;
				state_d    = S_EHASH;
			end
			S_EHASH: begin
				if (hash_done) begin
					state_d = S_EWALK;
					if (SLOT_W'(hole_q - hash_home) < SLOT_W'(e_q - hash_home)) begin
						mem_we    = 1'b1;
						mem_waddr = hole_q;
						mem_wdata = rd_q;
						set_used  = 1'b1;
						set_idx   = hole_q;
						clr_used  = 1'b1;
						clr_idx   = e_q;
						hole_d    = e_q;
						e_d       = end_q;
					end else begin
						e_d = e_q - SLOT_W'(1);
					end
				end
			end
			S_DONE: begin
				if (load_out) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		used_d = used_q;
		if (clr_used) used_d[clr_idx] = 1'b0;
		if (set_used) used_d[set_idx] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			used_q  <= used_d;
			if (load_out) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= req.mode;
			key_q  <= key_trim(req.key);
			val_q  <= req.data_value;
			typ_q  <= req.data_type;
		end
		idx_q  <= idx_d;
		n_q    <= n_d;
		hole_q <= hole_d;
		e_q    <= e_d;
		end_q  <= end_d;
		st_q   <= st_d;
		sl_q   <= sl_d;
		fv_q   <= fv_d;
		ft_q   <= ft_d;
		if (load_out) begin
			out_st_q  <= st_q;
			out_sl_q  <= sl_q;
			out_fv_q  <= fv_q;
			out_ft_q  <= ft_q;
			out_cnt_q <= count_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rd_q <= mem[mem_raddr];
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_st_q;
	assign rsp.slot        = out_sl_q;
	assign rsp.found_value = out_fv_q;
	assign rsp.found_type  = out_ft_q;
	assign rsp.entry_count = out_cnt_q;
endmodule
`default_nettype wire
